// ----- hdl/lpc_pkg.sv -----
// Shared types, constants and helpers for the page cache tag controller.
// No dependencies; every other file of the block imports this package.
package lpc_pkg;

  // Cache geometry and field widths.
  localparam int CACHE_SLOTS  = 16;
  localparam int SLOT_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int PAGE_W       = 32;
  localparam int OP_W         = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int CNT_W        = 16;

  localparam logic [CNT_W-1:0] CKPT_THRESHOLD_RESET = 16'd1000;

  typedef logic [SLOT_W-1:0]       slot_id_t;
  typedef logic [PAGE_W-1:0]       page_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Operation codes carried in the op field; code 3 is ignored.
  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_DEALLOC = 2'd2
  } op_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_t;

  // One recency position: the slot it names, the page held there and its valid bit.
  typedef struct packed {
    slot_id_t slot_id;
    page_t    tag;
    logic     valid;
  } entry_t;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic lookup;    // compare the key and latch the match flags
    logic mru_hit;   // move the hit entry to the head
    logic mru_miss;  // refill the tail entry and move it to the head
    logic lru_hit;   // invalidate the hit entry and move it to the tail
  } cell_cmd_t;

  // Sequencing signals from the controller.
  typedef struct packed {
    logic in_ready;
    logic lookup;
    logic commit;
    logic out_valid;
  } ctrl_t;

  // Low bits of a slot number as carried in the slot field.
  function automatic slot_field_t slot_field(input slot_id_t s);
    logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
    ext = {{SLOT_FIELD_W{1'b0}}, s};
    return ext[SLOT_FIELD_W-1:0];
  endfunction

endpackage

// ----- hdl/lpc_in_if.sv -----
// Request channel: valid/ready handshake with the op and page number.
// Depends on lpc_pkg for the field widths.
interface lpc_in_if;
  import lpc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [PAGE_W-1:0]   page_number;

  modport source (output valid, output op, output page_number, input ready);
  modport sink   (input valid, input op, input page_number, output ready);
endinterface

// ----- hdl/lpc_out_if.sv -----
// Result channel: valid/ready handshake with the lookup and eviction result.
// Depends on lpc_pkg for the field widths.
interface lpc_out_if;
  import lpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [SLOT_FIELD_W-1:0] slot;
  logic                    fetch_from_store;
  logic                    write_to_store;
  logic                    evicted_valid;
  logic [PAGE_W-1:0]       evicted_page;
  logic                    checkpoint;

  modport source (output valid, output hit, output slot, output fetch_from_store,
                  output write_to_store, output evicted_valid, output evicted_page,
                  output checkpoint, input ready);
  modport sink   (input valid, input hit, input slot, input fetch_from_store,
                  input write_to_store, input evicted_valid, input evicted_page,
                  input checkpoint, output ready);
endinterface

// ----- hdl/lpc_cell.sv -----
// One recency position of the LRU row: holds slot number, tag and valid bit.
// Depends on lpc_pkg; instantiated once per slot by the top level.
module lpc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  lpc_pkg::slot_id_t reset_slot,
  input  lpc_pkg::page_t    key,
  input  lpc_pkg::cell_cmd_t cmd,
  input  lpc_pkg::entry_t   left_in,
  input  lpc_pkg::entry_t   right_in,
  input  logic             before_in,
  output logic             before_out,
  output lpc_pkg::entry_t   entry,
  output logic             match
);
  import lpc_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   match_r, before_r;
  logic   match_now;

  // Tag compare; an invalid entry never matches.
  assign match_now  = entry_r.valid && (entry_r.tag == key);
  assign before_out = before_in | match_now;

  // Shift from a neighbor or hold. The hit position and everything nearer the
  // head move toward the tail on a hit; everything moves on a miss; on an
  // invalidate the hit position and everything behind it move toward the head.
  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.mru_miss) begin
      entry_nxt = left_in;
    end else if (cmd.mru_hit && !before_r) begin
      entry_nxt = left_in;
    end else if (cmd.lru_hit && (before_r || match_r)) begin
      entry_nxt = right_in;
    end
  end

  // Entry and match flag registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r  <= '{slot_id: reset_slot, tag: '0, valid: 1'b0};
      match_r  <= 1'b0;
      before_r <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      if (cmd.lookup) begin
        match_r  <= match_now;
        before_r <= before_in;
      end
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

// ----- hdl/lpc_ctrl.sv -----
// Sequencer for the page cache: accept, lookup cycle, update cycle, result register.
// Depends on lpc_pkg for the state and control struct types.
module lpc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_ready,
  output lpc_pkg::ctrl_t ctrl
);
  import lpc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   commit;

  assign out_free = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   state_nxt = in_valid ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = in_valid ? ST_LOOKUP : ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: a new request is taken in the cycle the previous one commits.
  always_comb begin
    commit = (state_r == ST_UPDATE) && out_free;
    ctrl.commit    = commit;
    ctrl.lookup    = (state_r == ST_LOOKUP);
    ctrl.in_ready  = (state_r == ST_IDLE) || commit;
    ctrl.out_valid = out_valid_r;
  end

  // The result register is full from commit until its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted request is looked up in the following cycle.
  a_accept_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && ctrl.in_ready) |=> (state_r == ST_LOOKUP))
    else $error("accepted request did not enter lookup");

  // A lookup is always followed by the update cycle.
  a_lookup_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |=> (state_r == ST_UPDATE))
    else $error("lookup not followed by update");

  // A commit leaves a result waiting in the output register.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit did not load the result register");

  // The update waits while an untaken result still occupies the register.
  a_update_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPDATE) && out_valid_r && !out_ready) |=> (state_r == ST_UPDATE))
    else $error("update overwrote a pending result");

endmodule

// ----- hdl/lru_page_cache_tag_controller_top.sv -----
// Top level of the page cache tag controller: cell row, sequencer, counter, result.
// Depends on lpc_pkg, lpc_in_if, lpc_out_if, lpc_cell and lpc_ctrl.
//
// Tag and LRU replacement control for a fully associative cache of
// CACHE_SLOTS page slots. Each request has a lookup cycle, in which every
// cell of the recency row compares its tag with the page number, and an
// update cycle, in which the row shifts by one position to move the touched
// slot to the head (read or write) or to the tail (deallocate hit). A request
// is accepted in the same cycle its predecessor commits; the result is loaded
// into the output register at commit, and the row waits in its update cycle
// while an earlier result has not been transferred. The recency row is ready
// right after reset, with slot 0 newest and the last slot oldest. The user
// must write the checkpoint threshold through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this.
module lru_page_cache_tag_controller_top (
  input  logic                 clk,
  input  logic                 rst_n,
  lpc_in_if.sink               in_if,
  lpc_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [lpc_pkg::CNT_W-1:0] cfg_wdata
);
  import lpc_pkg::*;

  ctrl_t      ctrl;
  cell_cmd_t  cmd;
  logic [OP_W-1:0] op_r;
  page_t      page_r;
  cnt_t       wr_cnt_r, wr_cnt_nxt;
  cnt_t       thr_r;

  entry_t     cell_entry [CACHE_SLOTS];
  logic [CACHE_SLOTS-1:0] cell_match;
  logic [CACHE_SLOTS-1:0] cell_before_out;
  entry_t     head_entry, tail_entry, victim;
  logic       hit;
  slot_id_t   hit_slot;
  logic       ckpt_now;

  // Result register fields.
  logic        res_hit_r, res_fetch_r, res_wr_r, res_ev_valid_r, res_ckpt_r;
  slot_field_t res_slot_r;
  page_t       res_ev_page_r;
  logic        res_hit_nxt, res_fetch_nxt, res_wr_nxt, res_ev_valid_nxt, res_ckpt_nxt;
  slot_field_t res_slot_nxt;
  page_t       res_ev_page_nxt;

  // Sequencer.
  lpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .out_ready (out_if.ready),
    .ctrl      (ctrl)
  );

  assign in_if.ready = ctrl.in_ready;

  // Request capture on each input transfer.
  always_ff @(posedge clk) begin
    if (in_if.valid && ctrl.in_ready) begin
      op_r   <= in_if.op;
      page_r <= in_if.page_number;
    end
  end

  // Hit detection and one-hot selection of the hit slot number.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (cell_match[i]) begin
        hit_slot = hit_slot | cell_entry[i].slot_id;
      end
    end
  end

  assign hit    = |cell_match;
  assign victim = cell_entry[CACHE_SLOTS-1];

  // Entries entering the row at its ends.
  always_comb begin
    head_entry.slot_id = hit ? hit_slot : victim.slot_id;
    head_entry.tag     = page_r;
    head_entry.valid   = 1'b1;
    tail_entry.slot_id = hit_slot;
    tail_entry.tag     = page_r;
    tail_entry.valid   = 1'b0;
  end

  // Row command from the op and the lookup outcome.
  always_comb begin
    cmd        = '0;
    cmd.lookup = ctrl.lookup;
    if (ctrl.commit) begin
      unique case (op_r)
        OP_READ, OP_WRITE: begin
          cmd.mru_hit  = hit;
          cmd.mru_miss = !hit;
        end
        OP_DEALLOC: cmd.lru_hit = hit;
        default:    cmd = '{lookup: ctrl.lookup, default: 1'b0};
      endcase
    end
  end

  // The recency row.
  for (genvar g = 0; g < CACHE_SLOTS; g++) begin : g_cell
    entry_t left_in, right_in;
    logic   before_in;

    if (g == 0) begin : g_head
      assign left_in   = head_entry;
      assign before_in = 1'b0;
    end else begin : g_mid_l
      assign left_in   = cell_entry[g-1];
      assign before_in = cell_before_out[g-1];
    end

    if (g == CACHE_SLOTS - 1) begin : g_tail
      assign right_in = tail_entry;
    end else begin : g_mid_r
      assign right_in = cell_entry[g+1];
    end

    lpc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .reset_slot (slot_id_t'(g)),
      .key        (page_r),
      .cmd        (cmd),
      .left_in    (left_in),
      .right_in   (right_in),
      .before_in  (before_in),
      .before_out (cell_before_out[g]),
      .entry      (cell_entry[g]),
      .match      (cell_match[g])
    );
  end

  // Write counter: clears and flags a checkpoint when it meets the threshold.
  assign ckpt_now = (wr_cnt_r == thr_r);

  always_comb begin
    wr_cnt_nxt = wr_cnt_r;
    if (ctrl.commit && (op_r == OP_WRITE)) begin
      wr_cnt_nxt = ckpt_now ? '0 : wr_cnt_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_cnt_r <= '0;
      thr_r    <= CKPT_THRESHOLD_RESET;
    end else begin
      wr_cnt_r <= wr_cnt_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
    end
  end

  // Result fields; anything meaningless for the op stays zero.
  always_comb begin
    res_hit_nxt      = 1'b0;
    res_slot_nxt     = '0;
    res_fetch_nxt    = 1'b0;
    res_wr_nxt       = 1'b0;
    res_ev_valid_nxt = 1'b0;
    res_ev_page_nxt  = '0;
    res_ckpt_nxt     = 1'b0;
    unique case (op_r)
      OP_READ, OP_WRITE: begin
        res_hit_nxt  = hit;
        res_slot_nxt = slot_field(head_entry.slot_id);
        if (!hit) begin
          res_fetch_nxt    = (op_r == OP_READ);
          res_ev_valid_nxt = victim.valid;
          res_ev_page_nxt  = victim.valid ? victim.tag : '0;
        end
        if (op_r == OP_WRITE) begin
          res_wr_nxt   = 1'b1;
          res_ckpt_nxt = ckpt_now;
        end
      end
      OP_DEALLOC: begin
        res_hit_nxt  = hit;
        res_slot_nxt = hit ? slot_field(hit_slot) : '0;
      end
      default: res_hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      res_hit_r      <= res_hit_nxt;
      res_slot_r     <= res_slot_nxt;
      res_fetch_r    <= res_fetch_nxt;
      res_wr_r       <= res_wr_nxt;
      res_ev_valid_r <= res_ev_valid_nxt;
      res_ev_page_r  <= res_ev_page_nxt;
      res_ckpt_r     <= res_ckpt_nxt;
    end
  end

  assign out_if.valid            = ctrl.out_valid;
  assign out_if.hit              = res_hit_r;
  assign out_if.slot             = res_slot_r;
  assign out_if.fetch_from_store = res_fetch_r;
  assign out_if.write_to_store   = res_wr_r;
  assign out_if.evicted_valid    = res_ev_valid_r;
  assign out_if.evicted_page     = res_ev_page_r;
  assign out_if.checkpoint       = res_ckpt_r;

  // A page is valid in at most one slot, so at most one cell matches.
  a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> $onehot0(cell_match))
    else $error("page held valid in more than one slot");

  // A miss refill reuses the oldest slot, which lands at the head.
  a_miss_to_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mru_miss |=> (cell_entry[0].slot_id == $past(victim.slot_id)) && cell_entry[0].valid)
    else $error("miss refill did not land at the head");

  // A deallocate hit leaves an invalid entry at the tail.
  a_dealloc_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lru_hit |=> !cell_entry[CACHE_SLOTS-1].valid)
    else $error("deallocated slot not invalid at the tail");

endmodule
